// ===== design/hsv_pkg.sv =====
// Shared types and constants for the HSV to RGB converter pipeline.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package hsv_pkg;

	// Hue arithmetic, hue counted in 1/64 degree
	localparam logic [11:0] HUE_SECTOR   = 12'd3840;    // 60 degrees
	localparam logic [15:0] HUE_FULL     = 16'd23040;   // 360 degrees
	localparam logic [7:0]  FULL_SCALE   = 8'd255;
	localparam logic [19:0] SECTOR_SCALE = 20'd979200;  // 255 * 3840
	localparam logic [19:0] SECTOR_HALF  = 20'd489600;  // SECTOR_SCALE / 2
	localparam logic [15:0] P_BIAS       = 16'd127;     // floor(255 / 2)

	// Reciprocals for exact floor division of bounded values by a constant.
	// p: divide a 16-bit value by 255, shift 24.
	localparam int unsigned P_DIV   = 255;
	localparam int unsigned P_SHIFT = 24;
	localparam logic [16:0] P_RECIP =
		17'(((64'd1 << P_SHIFT) + 64'(P_DIV) - 64'd1) / 64'(P_DIV));
	// q and t: divide a 20-bit value by 3825 (979200 * 2 / 512), shift 32.
	localparam int unsigned Q_DIV   = 3825;
	localparam int unsigned Q_SHIFT = 32;
	localparam logic [20:0] Q_RECIP =
		21'(((64'd1 << Q_SHIFT) + 64'(Q_DIV) - 64'd1) / 64'(Q_DIV));

	// Hue sectors of the hexcone
	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} sector_t;

	// Sideband that travels with each pixel down the pipe
	typedef struct packed {
		sector_t    sector;
		logic       grey;     // zero saturation
		logic       over;     // hue beyond 360 degrees
		logic [7:0] bright;
		logic [7:0] alpha;
	} side_t;

	// Load enables for the arithmetic stages
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} scale_en_t;

endpackage

`default_nettype wire

// ===== design/hsv_sector.sv =====
// Stage 1 of the converter: hue sector, remainder and special-case flags.
// Depends on hsv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsv_sector (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [39:0]   s_tdata,
	output hsv_pkg::side_t     side_s1,
	output logic [11:0]        rem_s1,
	output logic [7:0]         sat_s1
);
	import hsv_pkg::*;

	localparam logic [15:0] SEC_W = 16'(HUE_SECTOR);

	logic [15:0] hue;
	logic [15:0] hh;
	logic [15:0] base;
	sector_t     sector;

	assign hue = s_tdata[15:0];
	assign hh  = (hue == HUE_FULL) ? 16'd0 : hue;

	always_comb begin
		priority if (hh >= 16'd5 * SEC_W) begin
			sector = SEC_MAG_RED;
			base   = 16'd5 * SEC_W;
		end else if (hh >= 16'd4 * SEC_W) begin
			sector = SEC_BLU_MAG;
			base   = 16'd4 * SEC_W;
		end else if (hh >= 16'd3 * SEC_W) begin
			sector = SEC_CYN_BLU;
			base   = 16'd3 * SEC_W;
		end else if (hh >= 16'd2 * SEC_W) begin
			sector = SEC_GRN_CYN;
			base   = 16'd2 * SEC_W;
		end else if (hh >= SEC_W) begin
			sector = SEC_YEL_GRN;
			base   = SEC_W;
		end else begin
			sector = SEC_RED_YEL;
			base   = 16'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.sector <= sector;
			side_s1.grey   <= (s_tdata[23:16] == 8'd0);
			side_s1.over   <= (hue > HUE_FULL);
			side_s1.bright <= s_tdata[31:24];
			side_s1.alpha  <= s_tdata[39:32];
			rem_s1         <= 12'(hh - base);
			sat_s1         <= s_tdata[23:16];
		end
	end

endmodule

`default_nettype wire

// ===== design/hsv_scale.sv =====
// Stages 2 to 5: products, rounding and division by constants for p, q, t.
// Depends on hsv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsv_scale (
	input  wire logic              clk,
	input  wire hsv_pkg::scale_en_t en,
	input  wire hsv_pkg::side_t    side_s1,
	input  wire logic [11:0]       rem_s1,
	input  wire logic [7:0]        sat_s1,
	output hsv_pkg::side_t         side_s5,
	output logic [7:0]             p_s5,
	output logic [7:0]             q_s5,
	output logic [7:0]             t_s5
);
	import hsv_pkg::*;

	side_t       side_s2, side_s3, side_s4;
	logic [19:0] prodq_s2, prodt_s2;
	logic [15:0] prodp_s2;
	logic [27:0] nq_s3, nt_s3;
	logic [15:0] mp_s3;
	logic [19:0] mq_s4, mt_s4;
	logic [7:0]  p_s4;

	logic [32:0] pp;
	logic [40:0] qq, tt;
	logic [27:0] nq_rnd, nt_rnd;

	// s*rem, s*(3840-rem), v*(255-s)
	always_ff @(posedge clk) begin
		if (en.s2) begin
			side_s2  <= side_s1;
			prodq_s2 <= 20'(sat_s1) * 20'(rem_s1);
			prodt_s2 <= 20'(sat_s1) * 20'(HUE_SECTOR - rem_s1);
			prodp_s2 <= 16'(side_s1.bright) * 16'(FULL_SCALE - sat_s1);
		end
	end

	// v*(979200 - x); p numerator halved: floor((2x + 255) / 2) = x + 127
	always_ff @(posedge clk) begin
		if (en.s3) begin
			side_s3 <= side_s2;
			nq_s3   <= 28'(side_s2.bright) * 28'(SECTOR_SCALE - prodq_s2);
			nt_s3   <= 28'(side_s2.bright) * 28'(SECTOR_SCALE - prodt_s2);
			mp_s3   <= prodp_s2 + P_BIAS;
		end
	end

	// floor((2n + 979200) / 512) = floor((n + 489600) / 256)
	assign nq_rnd = nq_s3 + 28'(SECTOR_HALF);
	assign nt_rnd = nt_s3 + 28'(SECTOR_HALF);
	assign pp     = 33'(mp_s3) * 33'(P_RECIP);

	always_ff @(posedge clk) begin
		if (en.s4) begin
			side_s4 <= side_s3;
			mq_s4   <= nq_rnd[27:8];
			mt_s4   <= nt_rnd[27:8];
			p_s4    <= pp[P_SHIFT +: 8];
		end
	end

	assign qq = 41'(mq_s4) * 41'(Q_RECIP);
	assign tt = 41'(mt_s4) * 41'(Q_RECIP);

	always_ff @(posedge clk) begin
		if (en.s5) begin
			side_s5 <= side_s4;
			q_s5    <= qq[Q_SHIFT +: 8];
			t_s5    <= tt[Q_SHIFT +: 8];
			p_s5    <= p_s4;
		end
	end

endmodule

`default_nettype wire

// ===== design/hsv_select.sv =====
// Output stage: six-way sector select, special cases, output register.
// Depends on hsv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsv_select (
	input  wire logic           clk,
	input  wire logic           en,
	input  wire hsv_pkg::side_t side_s5,
	input  wire logic [7:0]     p_s5,
	input  wire logic [7:0]     q_s5,
	input  wire logic [7:0]     t_s5,
	output logic [31:0]         rgba_s6
);
	import hsv_pkg::*;

	logic [7:0] r, g, b, a;
	logic [7:0] v;

	assign v = side_s5.bright;

	always_comb begin
		unique case (side_s5.sector)
			SEC_RED_YEL: begin r = v;    g = t_s5; b = p_s5; end
			SEC_YEL_GRN: begin r = q_s5; g = v;    b = p_s5; end
			SEC_GRN_CYN: begin r = p_s5; g = v;    b = t_s5; end
			SEC_CYN_BLU: begin r = p_s5; g = q_s5; b = v;    end
			SEC_BLU_MAG: begin r = t_s5; g = p_s5; b = v;    end
			default:     begin r = v;    g = p_s5; b = q_s5; end
		endcase
		// grey wins over an out-of-range hue
		priority if (side_s5.grey) begin
			r = v; g = v; b = v;
			a = side_s5.alpha;
		end else if (side_s5.over) begin
			r = 8'd0; g = 8'd0; b = 8'd0; a = 8'd0;
		end else begin
			a = side_s5.alpha;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rgba_s6 <= {a, b, g, r};
		end
	end

endmodule

`default_nettype wire

// ===== design/hsv_to_rgb_converter.sv =====
// HSV to RGB converter, six-stage pipeline. Throughput: one pixel per cycle
// while m_tready does not stall the output, fully pipelined; the multipliers
// of stages 2 to 5 set the stage depth.
// Each stage holds its own valid bit, so bubbles close up under back-pressure.
// Reset (arst_n low, asynchronous) clears all valid bits; data is not reset.
// Depends on hsv_pkg, hsv_sector, hsv_scale, hsv_select.
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_converter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave side
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // hue[15:0], saturation[23:16],
	                                    // brightness[31:24], alpha_in[39:32]
	// master side
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata    // red[7:0], green[15:8], blue[23:16],
	                                    // alpha_out[31:24]
);
	import hsv_pkg::*;

	// Valid bit per stage; stage 6 is the output register.
	logic [6:1] valid_q;
	logic [6:1] rdy;

	side_t       side_s1, side_s5;
	logic [11:0] rem_s1;
	logic [7:0]  sat_s1;
	logic [7:0]  p_s5, q_s5, t_s5;
	scale_en_t   scale_en;

	// A stage may load when it is empty or its content moves on this cycle.
	assign rdy[6] = !valid_q[6] || m_tready;
	assign rdy[5] = !valid_q[5] || rdy[6];
	assign rdy[4] = !valid_q[4] || rdy[5];
	assign rdy[3] = !valid_q[3] || rdy[4];
	assign rdy[2] = !valid_q[2] || rdy[3];
	assign rdy[1] = !valid_q[1] || rdy[2];

	assign s_tready = rdy[1];
	assign m_tvalid = valid_q[6];

	// Advance valid bits; a stage that cannot load holds its item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (rdy[1]) valid_q[1] <= s_tvalid;
			if (rdy[2]) valid_q[2] <= valid_q[1];
			if (rdy[3]) valid_q[3] <= valid_q[2];
			if (rdy[4]) valid_q[4] <= valid_q[3];
			if (rdy[5]) valid_q[5] <= valid_q[4];
			if (rdy[6]) valid_q[6] <= valid_q[5];
		end
	end

	assign scale_en.s2 = rdy[2];
	assign scale_en.s3 = rdy[3];
	assign scale_en.s4 = rdy[4];
	assign scale_en.s5 = rdy[5];

	// Stage 1: sector and remainder
	hsv_sector u_sector (
		.clk     (clk),
		.en      (rdy[1]),
		.s_tdata (s_tdata),
		.side_s1 (side_s1),
		.rem_s1  (rem_s1),
		.sat_s1  (sat_s1)
	);

	// Stages 2 to 5: p, q, t
	hsv_scale u_scale (
		.clk     (clk),
		.en      (scale_en),
		.side_s1 (side_s1),
		.rem_s1  (rem_s1),
		.sat_s1  (sat_s1),
		.side_s5 (side_s5),
		.p_s5    (p_s5),
		.q_s5    (q_s5),
		.t_s5    (t_s5)
	);

	// Stage 6: channel select into the output register
	hsv_select u_select (
		.clk     (clk),
		.en      (rdy[6]),
		.side_s5 (side_s5),
		.p_s5    (p_s5),
		.q_s5    (q_s5),
		.t_s5    (t_s5),
		.rgba_s6 (m_tdata)
	);

`ifndef SYNTHESIS
	// A ready sink lets every stage move, so the input is open too.
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("s_tready low while m_tready high");

	// An empty pipe always takes a transaction.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q == '0) |-> s_tready)
		else $error("empty pipeline not ready");

	// A blocked stage keeps its item.
	a_hold_s5: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q[5] && !rdy[5]) |=> valid_q[5])
		else $error("stage 5 dropped a stalled item");

	// Output stalls back up into stage 5 only when stage 5 is occupied.
	a_stall_path: assert property (@(posedge clk) disable iff (!arst_n)
		(!rdy[5]) |-> (valid_q[5] && valid_q[6] && !m_tready))
		else $error("stage 5 stalled without a blocked output");
`endif

endmodule

`default_nettype wire

// ===== sim/hsv_to_rgb_converter_test.sv =====
// Self-checking bench for hsv_to_rgb_converter: streams HSV pixels through the
// stream ports, predicts each RGBA result and compares it as it leaves.
// Depends on hsv_pkg and the design top level only.
`timescale 1ns / 1ps

module hsv_to_rgb_converter_test;
	import hsv_pkg::*;

	localparam int unsigned RANDOM_PIXELS = 1250;
	localparam int unsigned CYCLE_LIMIT   = 60000;
	localparam int unsigned HOLD_CYCLES   = 200;   // long receiver hold-off
	localparam int unsigned HOLD_AT       = 300;   // pixels accepted before it
	localparam int unsigned DRAIN_CYCLES  = 16;    // pipeline is 6 deep

	// Expected-pixel store and field compare
	class pixel_scoreboard;
		logic [31:0] rgba_queue[$];
		int unsigned errors;
		int unsigned accepted;

		function automatic longint unsigned round_div(longint unsigned num,
				longint unsigned den);
			return (2 * num + den) / (2 * den);
		endfunction

		// hexcone conversion, all channels rounded to nearest with ties up
		function automatic logic [31:0] hsv_to_rgba(logic [39:0] px);
			longint unsigned h, s, v, hh, rem, p, q, t;
			logic [7:0] r, g, b, ao;
			sector_t sec;
			h = px[15:0];
			s = px[23:16];
			v = px[31:24];
			ao = px[39:32];
			if (s == 0) begin
				r = v[7:0];
				g = v[7:0];
				b = v[7:0];
			end else if (h > HUE_FULL) begin
				r = '0;
				g = '0;
				b = '0;
				ao = '0;
			end else begin
				hh = (h == HUE_FULL) ? 0 : h;
				sec = sector_t'(3'(hh / HUE_SECTOR));
				rem = hh % HUE_SECTOR;
				p = round_div(v * (FULL_SCALE - s), FULL_SCALE);
				q = round_div(v * (SECTOR_SCALE - s * rem), SECTOR_SCALE);
				t = round_div(v * (SECTOR_SCALE - s * (HUE_SECTOR - rem)), SECTOR_SCALE);
				case (sec)
					SEC_RED_YEL: begin r = v[7:0]; g = t[7:0]; b = p[7:0]; end
					SEC_YEL_GRN: begin r = q[7:0]; g = v[7:0]; b = p[7:0]; end
					SEC_GRN_CYN: begin r = p[7:0]; g = v[7:0]; b = t[7:0]; end
					SEC_CYN_BLU: begin r = p[7:0]; g = q[7:0]; b = v[7:0]; end
					SEC_BLU_MAG: begin r = t[7:0]; g = p[7:0]; b = v[7:0]; end
					default: begin r = v[7:0]; g = p[7:0]; b = q[7:0]; end
				endcase
			end
			return {ao, b, g, r};
		endfunction

		function void note_input(logic [39:0] px);
			rgba_queue.push_back(hsv_to_rgba(px));
			accepted++;
		endfunction

		function void check_result(logic [31:0] actual);
			string names[4] = '{"red", "green", "blue", "alpha_out"};
			logic [31:0] want;
			if (rgba_queue.size() == 0) begin
				$display("%0t: unexpected pixel %h", $time, actual);
				errors++;
				return;
			end
			want = rgba_queue.pop_front();
			for (int i = 0; i < 4; i++) begin
				if (actual[8*i +: 8] !== want[8*i +: 8]) begin
					$display("%0t: %s expected %0d actual %0d", $time, names[i],
						want[8*i +: 8], actual[8*i +: 8]);
					errors++;
				end
			end
		endfunction

		function int unsigned pending();
			return rgba_queue.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;   // hue[15:0], saturation[23:16], brightness[31:24],
	                             // alpha_in[39:32]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // red[7:0], green[15:8], blue[23:16], alpha_out[31:24]

	pixel_scoreboard sb = new();
	bit          gaps_on = 1'b1;   // random idling on both sides
	int unsigned cycle_count;

	hsv_to_rgb_converter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watch both handshakes at the edge; values read here are the pre-edge ones.
	always @(posedge clk) begin
		cycle_count++;
		if (s_tvalid && s_tready)
			sb.note_input(s_tdata);
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata);
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver: random stalls, plus one long hold-off so the pipe fills and
	// back-pressure reaches the input.
	initial begin
		int unsigned hold_left;
		bit          hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!hold_done && sb.accepted >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (gaps_on && $urandom_range(99) < 16)
				m_tready <= 1'b0;
			else
				m_tready <= 1'b1;
		end
	end

	// Offer one pixel, with a random idle gap ahead of it; return once accepted.
	task automatic send_pixel(input logic [15:0] hue, input logic [7:0] sat,
			input logic [7:0] bright, input logic [7:0] alpha);
		while (gaps_on && $urandom_range(99) < 16) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {alpha, bright, sat, hue};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	function automatic logic [15:0] pick_hue();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 8)
			return 16'($urandom_range(0, 6) * HUE_SECTOR + $urandom_range(0, 2) - 1);
		else if (roll < 18)
			return 16'($urandom_range(0, 65535));
		else
			return 16'($urandom_range(0, HUE_FULL));
	endfunction

	initial begin
		logic [7:0] sat;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: sector boundaries, hue wrap at 360 degrees, out-of-range hue,
		// zero saturation (also with an out-of-range hue), field extremes.
		send_pixel(16'd0,     8'd255, 8'd255, 8'd255);
		send_pixel(16'd3839,  8'd255, 8'd255, 8'd0);
		send_pixel(16'd3840,  8'd255, 8'd255, 8'd17);
		send_pixel(16'd7679,  8'd200, 8'd128, 8'd34);
		send_pixel(16'd7680,  8'd255, 8'd255, 8'd51);
		send_pixel(16'd11520, 8'd128, 8'd255, 8'd68);
		send_pixel(16'd15360, 8'd255, 8'd100, 8'd85);
		send_pixel(16'd19200, 8'd1,   8'd255, 8'd102);
		send_pixel(16'd23039, 8'd255, 8'd255, 8'd119);
		send_pixel(16'd23040, 8'd255, 8'd255, 8'd136);
		send_pixel(16'd23040, 8'd77,  8'd200, 8'd153);
		send_pixel(16'd23041, 8'd255, 8'd255, 8'd170);
		send_pixel(16'd65535, 8'd1,   8'd255, 8'd255);
		send_pixel(16'd65535, 8'd0,   8'd255, 8'd255);
		send_pixel(16'd30000, 8'd0,   8'd42,  8'd187);
		send_pixel(16'd1920,  8'd0,   8'd0,   8'd0);
		send_pixel(16'd1920,  8'd255, 8'd0,   8'd204);
		send_pixel(16'd1920,  8'd255, 8'd1,   8'd221);
		send_pixel(16'd9600,  8'd254, 8'd254, 8'd238);
		send_pixel(16'd1,     8'd255, 8'd255, 8'd255);
		send_pixel(16'd17280, 8'd128, 8'd127, 8'd1);

		// Random pixels; a middle stretch runs with no idling on either side.
		for (int unsigned n = 0; n < RANDOM_PIXELS; n++) begin
			gaps_on = !(n >= 500 && n < 800);
			sat = ($urandom_range(99) < 8) ? 8'd0 : 8'($urandom_range(0, 255));
			send_pixel(pick_hue(), sat, 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)));
		end
		s_tvalid <= 1'b0;

		// Drain: wait for every expected pixel, then let the pipe settle.
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
